>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation builds get concurrent
// assertions; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/clx_pkg.sv
`default_nettype none

package clx_pkg;

   // Default number of word characters kept for keyword matching.
   localparam int WORD_COMPARE_LEN_DEFAULT = 8;

   // Leading word characters the keyword matcher looks at (longest keyword).
   localparam int PREFIX_HEAD_BYTES = 6;
   localparam int PREFIX_HEAD_W     = 8 * PREFIX_HEAD_BYTES;

   typedef enum logic [3:0] {
      ST_INIT   = 4'd0,
      ST_WORD   = 4'd1,
      ST_NUMBER = 4'd2,
      ST_SYMBOL = 4'd3,
      ST_STRING = 4'd4,
      ST_ESC    = 4'd5,
      ST_OPER   = 4'd6,
      ST_PLUS   = 4'd7,
      ST_MINUS  = 4'd8,
      ST_DOT    = 4'd9,
      ST_REAL   = 4'd10
   } scan_state_type;

   typedef enum logic [3:0] {
      TK_BOOL     = 4'd0,
      TK_NIL      = 4'd1,
      TK_IDENT    = 4'd2,
      TK_INT      = 4'd3,
      TK_OPER     = 4'd4,
      TK_REAL     = 4'd5,
      TK_RESERVED = 4'd6,
      TK_SPECIAL  = 4'd7,
      TK_STRING   = 4'd8,
      TK_SYMBOL   = 4'd9,
      TK_END      = 4'd10,
      TK_UNTERM   = 4'd11
   } token_kind_type;

   typedef struct packed {
      scan_state_type state;
      logic [15:0]    count;
      logic [31:0]    accum;
      logic           neg;
   } scan_regs_type;

   typedef struct packed {
      logic           valid;
      token_kind_type kind;
      logic           bool_value;
      logic [31:0]    int_value;
      logic [3:0]     keyword_index;
      logic [15:0]    lexeme_length;
   } token_type;

   typedef struct packed {
      scan_regs_type regs;
      token_type     tok_a;
      token_type     tok_b;
      logic          run_init;
      logic          prefix_we;
      logic          prefix_at_zero;
   } step_out_type;

   typedef struct packed {
      token_kind_type kind;
      logic           bool_value;
      logic [31:0]    int_value;
      logic [3:0]     keyword_index;
      logic [15:0]    lexeme_length;
      logic [23:0]    start_pos;
      logic [15:0]    start_col;
      logic [19:0]    start_line;
      logic           last;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/clx_step.sv
`default_nettype none

// Next-state and token logic for one character: the pass in the current
// state, followed when needed by the pass in the initial state.
module clx_step
   import clx_pkg::*;
(
   input  wire scan_regs_type             regs,
   input  wire logic [7:0]                character,
   input  wire logic [PREFIX_HEAD_W-1:0]  prefix_head,
   output step_out_type                   step_out
);

   localparam int KW_COUNT = 13;
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";
   localparam logic [7:0] CH_UA     = "A";
   localparam logic [7:0] CH_UZ     = "Z";
   localparam logic [7:0] CH_LA     = "a";
   localparam logic [7:0] CH_LZ     = "z";
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_COLON  = ":";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_PCT    = "%";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Reserved words, left-justified with zero padding.
   localparam logic [PREFIX_HEAD_W-1:0] KW_TEXT [KW_COUNT] = '{
      {"catch", 8'h00}, {"do", 32'h0}, {"else", 16'h0}, {"end", 24'h0},
      {"fun", 24'h0}, {"if", 32'h0}, {"in", 32'h0}, {"let", 24'h0},
      {"letrec"}, {"macro", 8'h00}, {"record"}, {"then", 16'h0},
      {"try", 24'h0}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd2, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd6, 3'd5, 3'd6, 3'd4, 3'd3
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CH_UA) && (c <= CH_UZ);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= CH_LA) && (c <= CH_LZ);
   endfunction

   function automatic logic is_wordch(input logic [7:0] c);
      return is_upper(c) || is_lower(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return (c == CH_DOT) || (c == CH_COLON) || (c == CH_PLUS) ||
             (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
             (c == CH_EQUAL) || (c == CH_PCT);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
   endfunction

   function automatic token_type make_token(input token_kind_type kind,
                                            input logic [31:0] int_value,
                                            input logic [15:0] len);
      token_type t;
      t               = '0;
      t.valid         = 1'b1;
      t.kind          = kind;
      t.int_value     = int_value;
      t.lexeme_length = len;
      return t;
   endfunction

   // Sorts a finished word into boolean, nil, reserved word or identifier.
   function automatic token_type word_token(input logic [PREFIX_HEAD_W-1:0] head,
                                            input logic [15:0] count);
      token_type              t;
      logic [PREFIX_HEAD_W-1:0] mask;
      logic                   hit;
      int                     i;
      t   = make_token(TK_IDENT, 32'd0, count);
      hit = 1'b0;
      for (i = 0; i < KW_COUNT; i++) begin
         mask = {PREFIX_HEAD_W{1'b1}} << (8 * (PREFIX_HEAD_BYTES - int'(KW_LEN[i])));
         if (!hit && (count == 16'(KW_LEN[i])) && ((head & mask) == KW_TEXT[i])) begin
            hit             = 1'b1;
            t.kind          = TK_RESERVED;
            t.keyword_index = 4'(i);
         end
      end
      if ((count == 16'd4) && (head[PREFIX_HEAD_W-1 -: 32] == "true")) begin
         t.kind          = TK_BOOL;
         t.bool_value    = 1'b1;
         t.keyword_index = 4'd0;
      end else if ((count == 16'd5) && (head[PREFIX_HEAD_W-1 -: 40] == "false")) begin
         t.kind          = TK_BOOL;
         t.keyword_index = 4'd0;
      end else if ((count == 16'd3) && (head[PREFIX_HEAD_W-1 -: 24] == "nil")) begin
         t.kind          = TK_NIL;
         t.keyword_index = 4'd0;
      end
      return t;
   endfunction

   logic [15:0]   count_inc;
   logic [31:0]   digit_val;
   logic [31:0]   accum_next;
   scan_regs_type cleared;
   scan_regs_type mid;

   assign count_inc  = (regs.count == 16'hFFFF) ? regs.count : regs.count + 16'd1;
   assign digit_val  = {28'd0, character[3:0]};
   assign accum_next = (regs.accum << 3) + (regs.accum << 1) + digit_val;

   always_comb begin
      cleared       = '0;
      cleared.state = ST_INIT;
   end

   always_comb begin
      step_out                = '0;
      mid                     = regs;
      step_out.run_init       = 1'b0;

      // Pass in the current state.
      unique case (regs.state)
         ST_WORD: begin
            if (is_wordch(character)) begin
               mid.count          = count_inc;
               step_out.prefix_we = 1'b1;
            end else begin
               step_out.tok_a    = word_token(prefix_head, regs.count);
               step_out.run_init = 1'b1;
            end
         end
         ST_SYMBOL: begin
            if (is_wordch(character)) begin
               mid.count = count_inc;
            end else begin
               step_out.tok_a    = make_token(TK_SYMBOL, 32'd0, regs.count);
               step_out.run_init = 1'b1;
            end
         end
         ST_NUMBER: begin
            if (is_digit(character)) begin
               mid.count = count_inc;
               mid.accum = accum_next;
            end else if (character == CH_DOT) begin
               mid.count = count_inc;
               mid.state = ST_DOT;
            end else begin
               step_out.tok_a = make_token(TK_INT,
                  regs.neg ? (32'd0 - regs.accum) : regs.accum, regs.count);
               step_out.run_init = 1'b1;
            end
         end
         ST_STRING: begin
            if (character == CH_BSLASH) begin
               mid.state = ST_ESC;
            end else if (character == CH_QUOTE) begin
               step_out.tok_a = make_token(TK_STRING, 32'd0, regs.count);
               mid            = cleared;
            end else if (character == CH_NUL) begin
               step_out.tok_a = make_token(TK_UNTERM, 32'd0, 16'd0);
               mid            = cleared;
            end else begin
               mid.count = count_inc;
            end
         end
         ST_ESC: begin
            mid.count = count_inc;
            mid.state = ST_STRING;
         end
         ST_OPER: begin
            if (is_oper(character)) begin
               mid.count = count_inc;
            end else begin
               step_out.tok_a    = make_token(TK_OPER, 32'd0, regs.count);
               step_out.run_init = 1'b1;
            end
         end
         ST_PLUS, ST_MINUS: begin
            // A sign arrives with an empty lexeme; plus is dropped before a digit.
            if (is_digit(character)) begin
               mid.accum = digit_val;
               mid.state = ST_NUMBER;
               if (regs.state == ST_MINUS) begin
                  mid.count = 16'd2;
                  mid.neg   = 1'b1;
               end else begin
                  mid.count = 16'd1;
               end
            end else if (is_oper(character)) begin
               mid.count = 16'd2;
               mid.state = ST_OPER;
            end else begin
               step_out.tok_a    = make_token(TK_OPER, 32'd0, 16'd1);
               step_out.run_init = 1'b1;
            end
         end
         ST_DOT: begin
            if (is_digit(character)) begin
               mid.count = count_inc;
               mid.state = ST_REAL;
            end else begin
               // A bare trailing dot gets an implied zero in the lexeme.
               step_out.tok_a    = make_token(TK_REAL, 32'd0, count_inc);
               step_out.run_init = 1'b1;
            end
         end
         ST_REAL: begin
            if (is_digit(character)) begin
               mid.count = count_inc;
            end else begin
               step_out.tok_a    = make_token(TK_REAL, 32'd0, regs.count);
               step_out.run_init = 1'b1;
            end
         end
         default: begin
            step_out.run_init = 1'b1;
         end
      endcase

      // Pass in the initial state, on cleared registers.
      if (step_out.run_init) begin
         mid = cleared;
         if (is_upper(character)) begin
            mid.count               = 16'd1;
            mid.state               = ST_SYMBOL;
         end else if (is_lower(character)) begin
            mid.count               = 16'd1;
            mid.state               = ST_WORD;
            step_out.prefix_we      = 1'b1;
            step_out.prefix_at_zero = 1'b1;
         end else if (is_digit(character)) begin
            mid.count = 16'd1;
            mid.accum = digit_val;
            mid.state = ST_NUMBER;
         end else if (character == CH_PLUS) begin
            mid.state = ST_PLUS;
         end else if (character == CH_MINUS) begin
            mid.state = ST_MINUS;
         end else if (character == CH_QUOTE) begin
            mid.state = ST_STRING;
         end else if (is_oper(character)) begin
            mid.count = 16'd1;
            mid.state = ST_OPER;
         end else if (is_space(character)) begin
            mid = cleared;
         end else if (character == CH_NUL) begin
            step_out.tok_b = make_token(TK_END, 32'd0, 16'd0);
         end else begin
            step_out.tok_b = make_token(TK_SPECIAL, 32'd0, 16'd1);
         end
      end

      step_out.regs = mid;
   end

endmodule

`default_nettype wire

>>> hdl/character_lexer_core.sv
`default_nettype none

// Character lexer core. Feed one source character per transfer on the req_
// channel, with its offset, column and line; a zero byte marks end of input.
// Tokens leave on the rsp_ channel with their kind, value fields, lexeme
// length and start position, and rsp_last marks the final token that a
// character caused. A character is held in the input register and scanned
// there; its tokens are registered in the result register and offered
// from it. One character per cycle is taken while each character yields
// at most one token and rsp_stall is low; a character that both ends a token
// and yields a special or end token puts two tokens into the two-entry
// result register, which drains one transfer per cycle while not stalled.
// There is no clearing pass: the block accepts input right after reset.
module character_lexer_core
   import clx_pkg::*;
#(
   parameter int WORD_COMPARE_LEN = WORD_COMPARE_LEN_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_character,
   input  wire logic [23:0]        req_char_pos,
   input  wire logic [15:0]        req_char_col,
   input  wire logic [19:0]        req_char_line,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_token_kind,
   output logic                    rsp_bool_value,
   output logic signed [31:0]      rsp_int_value,
   output logic [3:0]              rsp_keyword_index,
   output logic [15:0]             rsp_lexeme_length,
   output logic [23:0]             rsp_start_pos,
   output logic [15:0]             rsp_start_col,
   output logic [19:0]             rsp_start_line,
   output logic                    rsp_last
);

   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(WORD_COMPARE_LEN);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  char_ff;
   logic [23:0] pos_ff;
   logic [15:0] col_ff;
   logic [19:0] line_ff;

   // Scanner state and token start position.
   scan_regs_type scan_ff;
   logic [23:0]   start_pos_ff;
   logic [15:0]   start_col_ff;
   logic [19:0]   start_line_ff;
   logic [7:0]    prefix_ff [WORD_COMPARE_LEN];

   // Result register: up to two tokens, slot0 is offered first.
   result_type  slot0_ff, slot1_ff;
   logic [1:0]  out_cnt_ff, out_cnt_in;

   step_out_type               step_out;
   logic [PREFIX_HEAD_W-1:0]   prefix_head;
   logic [15:0]                prefix_idx;
   result_type                 res_a, res_b;
   logic                       rsp_take;
   logic                       space_ok;
   logic                       advance;
   logic                       in_load;
   logic [1:0]                 new_cnt;

   // The keyword matcher sees the first six word characters, first one at the top.
   always_comb begin
      for (int i = 0; i < PREFIX_HEAD_BYTES; i++) begin
         prefix_head[8 * (PREFIX_HEAD_BYTES - 1 - i) +: 8] = prefix_ff[i];
      end
   end

   clx_step u_step (
      .regs        (scan_ff),
      .character   (char_ff),
      .prefix_head (prefix_head),
      .step_out    (step_out)
   );

   // A token from the pass in the current state keeps the stored start
   // position; one from the initial-state pass starts at this character.
   always_comb begin
      res_a.kind          = step_out.tok_a.kind;
      res_a.bool_value    = step_out.tok_a.bool_value;
      res_a.int_value     = step_out.tok_a.int_value;
      res_a.keyword_index = step_out.tok_a.keyword_index;
      res_a.lexeme_length = step_out.tok_a.lexeme_length;
      res_a.start_pos     = start_pos_ff;
      res_a.start_col     = start_col_ff;
      res_a.start_line    = start_line_ff;
      res_a.last          = !step_out.tok_b.valid;

      res_b.kind          = step_out.tok_b.kind;
      res_b.bool_value    = step_out.tok_b.bool_value;
      res_b.int_value     = step_out.tok_b.int_value;
      res_b.keyword_index = step_out.tok_b.keyword_index;
      res_b.lexeme_length = step_out.tok_b.lexeme_length;
      res_b.start_pos     = pos_ff;
      res_b.start_col     = col_ff;
      res_b.start_line    = line_ff;
      res_b.last          = 1'b1;
   end

   // The scanned character moves on only when both of its tokens fit.
   assign rsp_take  = (out_cnt_ff != 2'd0) && !rsp_stall;
   assign space_ok  = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_take);
   assign advance   = in_valid_ff && space_ok;
   assign in_load   = !in_valid_ff || advance;
   assign req_stall = !in_load;
   assign new_cnt   = {1'b0, step_out.tok_a.valid} + {1'b0, step_out.tok_b.valid};
   assign prefix_idx = step_out.prefix_at_zero ? 16'd0 : scan_ff.count;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = req_valid;
      end
      out_cnt_in = out_cnt_ff;
      if (advance) begin
         out_cnt_in = new_cnt;
      end else if (rsp_take) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_cnt_ff    <= 2'd0;
         scan_ff       <= '0;
         start_pos_ff  <= '0;
         start_col_ff  <= '0;
         start_line_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_cnt_ff  <= out_cnt_in;
         if (advance) begin
            scan_ff <= step_out.regs;
            if (step_out.run_init) begin
               start_pos_ff  <= pos_ff;
               start_col_ff  <= col_ff;
               start_line_ff <= line_ff;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_load) begin
         char_ff <= req_character;
         pos_ff  <= req_char_pos;
         col_ff  <= req_char_col;
         line_ff <= req_char_line;
      end
      if (advance && step_out.prefix_we && (prefix_idx < 16'(WORD_COMPARE_LEN))) begin
         prefix_ff[prefix_idx[IDX_W-1:0]] <= char_ff;
      end
      if (advance) begin
         if (step_out.tok_a.valid) begin
            slot0_ff <= res_a;
            slot1_ff <= res_b;
         end else begin
            slot0_ff <= res_b;
         end
      end else if (rsp_take) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_valid         = (out_cnt_ff != 2'd0);
   assign rsp_token_kind    = slot0_ff.kind;
   assign rsp_bool_value    = slot0_ff.bool_value;
   assign rsp_int_value     = $signed(slot0_ff.int_value);
   assign rsp_keyword_index = slot0_ff.keyword_index;
   assign rsp_lexeme_length = slot0_ff.lexeme_length;
   assign rsp_start_pos     = slot0_ff.start_pos;
   assign rsp_start_col     = slot0_ff.start_col;
   assign rsp_start_line    = slot0_ff.start_line;
   assign rsp_last          = slot0_ff.last;

   // The result register never holds more than two tokens.
   `ASSERT_ALWAYS(a_out_count_range, clock, reset, out_cnt_ff != 2'd3)
   // Every token emission clears the lexeme, so the initial state is always clean.
   `ASSERT_IMPLIES(a_init_clean, clock, reset, scan_ff.state == ST_INIT, (scan_ff.count == 16'd0) && (scan_ff.accum == 32'd0) && !scan_ff.neg)
   // A token that ends on this character can only come from a token in progress.
   `ASSERT_IMPLIES(a_first_needs_token, clock, reset, step_out.tok_a.valid, scan_ff.state != ST_INIT)
   // A character with two tokens leaves both queued.
   `ASSERT_NEXT(a_pair_queued, clock, reset, advance && step_out.tok_a.valid && step_out.tok_b.valid, out_cnt_ff == 2'd2)

endmodule

`default_nettype wire
